>>> rtl/core/msgpack_value_encoder_defines.svh
// ============================================================================
// MessagePack value encoder: assertion macros
// Property forms shared by the assertions of the encoder checker.
// ============================================================================
`ifndef MSGPACK_VALUE_ENCODER_DEFINES_SVH
`define MSGPACK_VALUE_ENCODER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define MVE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("encoder assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define MVE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("encoder assertion failed");

`endif

>>> rtl/core/msgpk_pkg.sv
// ============================================================================
// MessagePack encoder package
// Item kinds, format codes and the descriptor passed from front to back.
// ============================================================================
`default_nettype none

package msgpk_pkg;

  // Kinds of input item.
  typedef enum logic [3:0] {
    FuncUint    = 4'd0,
    FuncInt     = 4'd1,
    FuncStr     = 4'd2,
    FuncBin     = 4'd3,
    FuncBool    = 4'd4,
    FuncNil     = 4'd5,
    FuncFloat   = 4'd6,
    FuncArray   = 4'd7,
    FuncMap     = 4'd8,
    FuncPayload = 4'd9
  } func_e;

  // MessagePack format codes.
  localparam logic [7:0] CodeNil      = 8'hc0;
  localparam logic [7:0] CodeFalse    = 8'hc2;
  localparam logic [7:0] CodeTrue     = 8'hc3;
  localparam logic [7:0] CodeBin8     = 8'hc4;
  localparam logic [7:0] CodeBin16    = 8'hc5;
  localparam logic [7:0] CodeBin32    = 8'hc6;
  localparam logic [7:0] CodeFloat32  = 8'hca;
  localparam logic [7:0] CodeUint8    = 8'hcc;
  localparam logic [7:0] CodeUint16   = 8'hcd;
  localparam logic [7:0] CodeUint32   = 8'hce;
  localparam logic [7:0] CodeUint64   = 8'hcf;
  localparam logic [7:0] CodeInt8     = 8'hd0;
  localparam logic [7:0] CodeInt16    = 8'hd1;
  localparam logic [7:0] CodeInt32    = 8'hd2;
  localparam logic [7:0] CodeInt64    = 8'hd3;
  localparam logic [7:0] CodeStr8     = 8'hd9;
  localparam logic [7:0] CodeStr16    = 8'hda;
  localparam logic [7:0] CodeStr32    = 8'hdb;
  localparam logic [7:0] CodeArray16  = 8'hdc;
  localparam logic [7:0] CodeArray32  = 8'hdd;
  localparam logic [7:0] CodeMap16    = 8'hde;
  localparam logic [7:0] CodeMap32    = 8'hdf;
  localparam logic [7:0] CodeFixStr   = 8'ha0;
  localparam logic [7:0] CodeFixArray = 8'h90;
  localparam logic [7:0] CodeFixMap   = 8'h80;

  // Number of bytes that follow the head byte: 0 to 8.
  localparam int unsigned TailW = 4;

  // Default depth of the queue between front and back.
  localparam int unsigned FifoDepthDefault = 2;

  // One classified item: a head byte, then n_tail bytes taken from the top
  // of data, most significant byte first.
  typedef struct packed {
    logic [7:0]       head;
    logic [TailW-1:0] n_tail;
    logic [63:0]      data;
  } desc_t;

endpackage

`default_nettype wire

>>> rtl/core/msgpack_value_encoder.sv
// An item goes through the queue and then the output register once accepted.
// Throughput: one byte per cycle while out_ready_i is high and work is queued,
// set by the byte-wide output reg; item = head byte + 0, 1, 2, 4 or 8 tail bytes.
// A queue of FifoDepth items lets the input run ahead while bytes drain.
// Reset clears the queue pointers, the tail counter and the output valid.
// ============================================================================
// MessagePack value encoder
// Encodes typed 64-bit items into MessagePack bytes, 1 to 9 per defined item.
// ============================================================================
`default_nettype none

module msgpack_value_encoder #(
  parameter int unsigned FifoDepth = msgpk_pkg::FifoDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [3:0]  func_i,
  input  wire logic [63:0] value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             last_o
);

  msgpk_pkg::desc_t front_desc;
  msgpk_pkg::desc_t fifo_desc;
  logic             push;
  logic             pop;
  logic             fifo_full;
  logic             fifo_valid;

  // Front end: handshake and classification.
  msgpk_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .value_i     (value_i),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .desc_o      (front_desc)
  );

  // Queue of classified items.
  msgpk_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_desc),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .rdata_o (fifo_desc)
  );

  // Back end: byte serializer.
  msgpk_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_valid_i (fifo_valid),
    .desc_i       (fifo_desc),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/msgpk_front.sv
// ============================================================================
// MessagePack encoder front end
// Accepts items and classifies each into a head byte and big-endian tail.
// ============================================================================
`default_nettype none

module msgpk_front (
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [3:0]       func_i,
  input  wire logic [63:0]      value_i,
  input  wire logic             fifo_full_i,
  output logic                  push_o,
  output msgpk_pkg::desc_t      desc_o
);

  logic [7:0]                  head;
  logic [msgpk_pkg::TailW-1:0] n_tail;
  logic                        defined;
  logic [63:0]                 v;

  assign v = value_i;

  // Shortest form selection for each kind.
  always_comb begin
    head    = 8'h00;
    n_tail  = '0;
    defined = 1'b1;
    unique case (msgpk_pkg::func_e'(func_i))
      msgpk_pkg::FuncUint, msgpk_pkg::FuncInt: begin
        if (func_i == msgpk_pkg::FuncUint || !v[63]) begin
          // Non-negative values share the unsigned forms.
          priority if (v[63:7] == '0) begin
            head = v[7:0];
          end else if (v[63:8] == '0) begin
            head = msgpk_pkg::CodeUint8;   n_tail = 4'd1;
          end else if (v[63:16] == '0) begin
            head = msgpk_pkg::CodeUint16;  n_tail = 4'd2;
          end else if (v[63:32] == '0) begin
            head = msgpk_pkg::CodeUint32;  n_tail = 4'd4;
          end else begin
            head = msgpk_pkg::CodeUint64;  n_tail = 4'd8;
          end
        end else begin
          // Negative values: sign extension decides the width.
          priority if (&v[63:5]) begin
            head = v[7:0];
          end else if (&v[63:7]) begin
            head = msgpk_pkg::CodeInt8;    n_tail = 4'd1;
          end else if (&v[63:15]) begin
            head = msgpk_pkg::CodeInt16;   n_tail = 4'd2;
          end else if (&v[63:31]) begin
            head = msgpk_pkg::CodeInt32;   n_tail = 4'd4;
          end else begin
            head = msgpk_pkg::CodeInt64;   n_tail = 4'd8;
          end
        end
      end
      msgpk_pkg::FuncStr: begin
        priority if (v[63:5] == '0) begin
          head = msgpk_pkg::CodeFixStr | {3'b000, v[4:0]};
        end else if (v[63:8] == '0) begin
          head = msgpk_pkg::CodeStr8;    n_tail = 4'd1;
        end else if (v[63:16] == '0) begin
          head = msgpk_pkg::CodeStr16;   n_tail = 4'd2;
        end else begin
          head = msgpk_pkg::CodeStr32;   n_tail = 4'd4;
        end
      end
      msgpk_pkg::FuncBin: begin
        priority if (v[63:8] == '0) begin
          head = msgpk_pkg::CodeBin8;    n_tail = 4'd1;
        end else if (v[63:16] == '0) begin
          head = msgpk_pkg::CodeBin16;   n_tail = 4'd2;
        end else begin
          head = msgpk_pkg::CodeBin32;   n_tail = 4'd4;
        end
      end
      msgpk_pkg::FuncBool: begin
        head = (v != '0) ? msgpk_pkg::CodeTrue : msgpk_pkg::CodeFalse;
      end
      msgpk_pkg::FuncNil: begin
        head = msgpk_pkg::CodeNil;
      end
      msgpk_pkg::FuncFloat: begin
        head = msgpk_pkg::CodeFloat32;  n_tail = 4'd4;
      end
      msgpk_pkg::FuncArray: begin
        priority if (v[63:4] == '0) begin
          head = msgpk_pkg::CodeFixArray | {4'h0, v[3:0]};
        end else if (v[63:16] == '0) begin
          head = msgpk_pkg::CodeArray16; n_tail = 4'd2;
        end else begin
          head = msgpk_pkg::CodeArray32; n_tail = 4'd4;
        end
      end
      msgpk_pkg::FuncMap: begin
        priority if (v[63:4] == '0) begin
          head = msgpk_pkg::CodeFixMap | {4'h0, v[3:0]};
        end else if (v[63:16] == '0) begin
          head = msgpk_pkg::CodeMap16;   n_tail = 4'd2;
        end else begin
          head = msgpk_pkg::CodeMap32;   n_tail = 4'd4;
        end
      end
      msgpk_pkg::FuncPayload: begin
        head = v[7:0];
      end
      default: begin
        // Undefined kinds are taken and dropped without output.
        defined = 1'b0;
      end
    endcase
  end

  // Left-align the tail bytes so the back end always sends the top byte.
  always_comb begin
    desc_o.head   = head;
    desc_o.n_tail = n_tail;
    unique case (n_tail)
      4'd1:    desc_o.data = {v[7:0], 56'h0};
      4'd2:    desc_o.data = {v[15:0], 48'h0};
      4'd4:    desc_o.data = {v[31:0], 32'h0};
      default: desc_o.data = v;
    endcase
  end

  // Take an item whenever the queue has room.
  assign in_ready_o = !fifo_full_i;
  assign push_o     = in_valid_i && in_ready_o && defined;

endmodule

`default_nettype wire

>>> rtl/core/msgpk_fifo.sv
// ============================================================================
// MessagePack encoder descriptor queue
// Small flop-based queue that decouples the front end from the back end.
// ============================================================================
`default_nettype none

module msgpk_fifo #(
  parameter int unsigned Depth = msgpk_pkg::FifoDepthDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  msgpk_pkg::desc_t      wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output msgpk_pkg::desc_t      rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  msgpk_pkg::desc_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and fill count updates with wrap at the depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage holds payload only and needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/msgpk_back.sv
// ============================================================================
// MessagePack encoder back end
// Serializes one descriptor into bytes through a registered output stage.
// ============================================================================
`default_nettype none

module msgpk_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fifo_valid_i,
  input  msgpk_pkg::desc_t      desc_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic                  last_o
);

  logic [63:0]                 data_q, data_d;
  logic [msgpk_pkg::TailW-1:0] cnt_q, cnt_d;
  logic                        out_valid_q, out_valid_d;
  logic [7:0]                  out_byte_q, out_byte_d;
  logic                        last_q, last_d;
  logic                        out_free;

  // Load the output register from the tail shifter or from a new item.
  always_comb begin
    pop_o       = 1'b0;
    data_d      = data_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    last_d      = last_q;
    out_free    = !out_valid_q || out_ready_i;
    if (out_free) begin
      priority if (cnt_q != '0) begin
        out_byte_d  = data_q[63:56];
        last_d      = (cnt_q == msgpk_pkg::TailW'(1));
        data_d      = {data_q[55:0], 8'h00};
        cnt_d       = cnt_q - msgpk_pkg::TailW'(1);
        out_valid_d = 1'b1;
      end else if (fifo_valid_i) begin
        pop_o       = 1'b1;
        out_byte_d  = desc_i.head;
        last_d      = (desc_i.n_tail == '0);
        data_d      = desc_i.data;
        cnt_d       = desc_i.n_tail;
        out_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q     <= data_d;
    out_byte_q <= out_byte_d;
    last_q     <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

>>> rtl/core/msgpk_checker.sv
// ============================================================================
// MessagePack encoder port checker
// Watches the top-level ports for ordering and flow rules of the encoder.
// ============================================================================
`default_nettype none
`include "msgpack_value_encoder_defines.svh"

module msgpk_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [3:0]  func_i,
  input wire logic [63:0] value_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [7:0]  out_byte_o,
  input wire logic        last_o
);

  logic [7:0] pending_q, pending_d;
  logic       item_in;
  logic       item_out;
  logic       value_seen;

  // Count items that must still produce their last byte.
  assign item_in    = in_valid_i && in_ready_o && (func_i <= msgpk_pkg::FuncPayload);
  assign item_out   = out_valid_o && out_ready_i && last_o;
  assign value_seen = ^value_i || !(^value_i);

  always_comb begin
    pending_d = pending_q;
    if (item_in && !item_out) begin
      pending_d = pending_q + 8'd1;
    end else if (item_out && !item_in) begin
      pending_d = pending_q - 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // A stalled byte holds.
  `MVE_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_byte_o) && $stable(last_o))

  // No byte appears unless an item is still owed output.
  `MVE_ASSERT_IMP(a_no_invented, out_valid_o && value_seen, pending_q != 8'd0)

  // Bytes of one item follow each other without a gap.
  `MVE_ASSERT_NXT(a_tail_gapless, out_valid_o && out_ready_i && !last_o, out_valid_o)

  // The input only stalls while output is pending.
  `MVE_ASSERT_IMP(a_stall_has_output, !in_ready_o, out_valid_o)

endmodule

bind msgpack_value_encoder msgpk_checker u_msgpk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .func_i      (func_i),
  .value_i     (value_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_byte_o  (out_byte_o),
  .last_o      (last_o)
);

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// MessagePack value encoder testbench
// Feeds typed items (directed corner values, then random items and str/bin
// headers followed by their payload bytes) under random idling on both sides.
// Every item accepted is turned into the byte stream it should produce, and
// each byte leaving the encoder is compared against the oldest one predicted.
// ============================================================================
module tb_top;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 20;

  // One encoded byte as it should appear on the output channel.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } enc_byte_t;

  // Predicts the encoded stream of each accepted item and checks each byte.
  class msgpack_stream_checker;
    enc_byte_t   pending_bytes[$];
    int unsigned error_count;

    function new();
      error_count = 0;
    endfunction

    function void push_byte(logic [7:0] b);
      enc_byte_t nb;
      nb.data = b;
      nb.last = 1'b0;
      pending_bytes.push_back(nb);
    endfunction

    // Low n bytes of v, most significant first.
    function void push_be(logic [63:0] v, int n);
      for (int i = n - 1; i >= 0; i--) begin
        push_byte(v[8*i +: 8]);
      end
    endfunction

    function void encode_uint(logic [63:0] v);
      if (v <= 64'h7f) begin
        push_byte(v[7:0]);
      end else if (v <= 64'hff) begin
        push_byte(msgpk_pkg::CodeUint8);
        push_byte(v[7:0]);
      end else if (v <= 64'hffff) begin
        push_byte(msgpk_pkg::CodeUint16);
        push_be(v, 2);
      end else if (v <= 64'hffff_ffff) begin
        push_byte(msgpk_pkg::CodeUint32);
        push_be(v, 4);
      end else begin
        push_byte(msgpk_pkg::CodeUint64);
        push_be(v, 8);
      end
    endfunction

    function void encode_int(logic [63:0] v);
      if (!v[63]) begin
        encode_uint(v);
      end else if (v >= 64'hffff_ffff_ffff_ffe0) begin
        push_byte(v[7:0]);
      end else if (v >= 64'hffff_ffff_ffff_ff80) begin
        push_byte(msgpk_pkg::CodeInt8);
        push_byte(v[7:0]);
      end else if (v >= 64'hffff_ffff_ffff_8000) begin
        push_byte(msgpk_pkg::CodeInt16);
        push_be(v, 2);
      end else if (v >= 64'hffff_ffff_8000_0000) begin
        push_byte(msgpk_pkg::CodeInt32);
        push_be(v, 4);
      end else begin
        push_byte(msgpk_pkg::CodeInt64);
        push_be(v, 8);
      end
    endfunction

    // Length or count header; above 16 bits only the low 32 bits are sent.
    function void encode_header(logic [63:0] v, bit has_fix, logic [7:0] fix_base,
                                logic [63:0] fix_max, bit has8, logic [7:0] code8,
                                logic [7:0] code16, logic [7:0] code32);
      if (has_fix && v <= fix_max) begin
        push_byte(fix_base | v[7:0]);
      end else if (has8 && v <= 64'hff) begin
        push_byte(code8);
        push_byte(v[7:0]);
      end else if (v <= 64'hffff) begin
        push_byte(code16);
        push_be(v, 2);
      end else begin
        push_byte(code32);
        push_be(v, 4);
      end
    endfunction

    function void note_item(logic [3:0] f, logic [63:0] v);
      int unsigned base_count;
      enc_byte_t   tail_byte;
      base_count = pending_bytes.size();
      case (f)
        msgpk_pkg::FuncUint:    encode_uint(v);
        msgpk_pkg::FuncInt:     encode_int(v);
        msgpk_pkg::FuncStr: begin
          encode_header(v, 1'b1, msgpk_pkg::CodeFixStr, 64'd31, 1'b1,
                        msgpk_pkg::CodeStr8, msgpk_pkg::CodeStr16,
                        msgpk_pkg::CodeStr32);
        end
        msgpk_pkg::FuncBin: begin
          encode_header(v, 1'b0, 8'h00, 64'd0, 1'b1, msgpk_pkg::CodeBin8,
                        msgpk_pkg::CodeBin16, msgpk_pkg::CodeBin32);
        end
        msgpk_pkg::FuncBool: begin
          push_byte((v != 64'd0) ? msgpk_pkg::CodeTrue : msgpk_pkg::CodeFalse);
        end
        msgpk_pkg::FuncNil:     push_byte(msgpk_pkg::CodeNil);
        msgpk_pkg::FuncFloat: begin
          push_byte(msgpk_pkg::CodeFloat32);
          push_be(v, 4);
        end
        msgpk_pkg::FuncArray: begin
          encode_header(v, 1'b1, msgpk_pkg::CodeFixArray, 64'd15, 1'b0, 8'h00,
                        msgpk_pkg::CodeArray16, msgpk_pkg::CodeArray32);
        end
        msgpk_pkg::FuncMap: begin
          encode_header(v, 1'b1, msgpk_pkg::CodeFixMap, 64'd15, 1'b0, 8'h00,
                        msgpk_pkg::CodeMap16, msgpk_pkg::CodeMap32);
        end
        msgpk_pkg::FuncPayload: push_byte(v[7:0]);
        default: ;
      endcase
      // Mark the final byte of this item.
      if (pending_bytes.size() > base_count) begin
        tail_byte = pending_bytes.pop_back();
        tail_byte.last = 1'b1;
        pending_bytes.push_back(tail_byte);
      end
    endfunction

    function void check_byte(logic [7:0] b, logic l);
      enc_byte_t want;
      if (pending_bytes.size() == 0) begin
        $error("unexpected byte: out_byte 0x%02h last %0b with nothing pending", b, l);
        error_count++;
      end else begin
        want = pending_bytes.pop_front();
        if (b !== want.data) begin
          $error("out_byte mismatch: expected 0x%02h, actual 0x%02h", want.data, b);
          error_count++;
        end
        if (l !== want.last) begin
          $error("last mismatch: expected %0b, actual %0b", want.last, l);
          error_count++;
        end
      end
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [3:0]  func_i      = 4'd0;
  logic [63:0] value_i     = 64'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        last_o;

  bit          steady       = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned cycle_count  = 0;

  msgpack_stream_checker stream_check;

  msgpack_value_encoder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o),
    .last_o     (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("** msgpack_value_encoder: FAILED **");
      $finish;
    end
  end

  // Every byte taken from the encoder goes to the checker.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      stream_check.check_byte(out_byte_o, last_o);
    end
  end

  // Receiver: random stalls, a stall-free stretch, and one long hold-off.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_left = HoldCycles;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= steady || ($urandom_range(99) >= 21);
      end
    end
  end

  // Offers one item, starting and ending at a falling edge.
  task automatic send_item(input logic [3:0] f, input logic [63:0] v);
    while (!steady && $urandom_range(99) < 21) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    stream_check.note_item(f, v);
    @(negedge clk_i);
  endtask

  // Waits for a falling edge and then until no byte is outstanding.
  task automatic wait_for_drain();
    do @(negedge clk_i); while (stream_check.pending_bytes.size() != 0);
  endtask

  // Operand spread over small numbers, full words, every magnitude, negatives
  // of every magnitude and values next to a power of two.
  function automatic logic [63:0] rand_operand();
    logic [63:0] wide;
    int unsigned k;
    wide = {$urandom, $urandom};
    k = $urandom_range(63);
    case ($urandom_range(5))
      0: return 64'($urandom_range(40));
      1: return wide;
      2: return wide >> k;
      3: return ~(wide >> k);
      4: begin
        wide = (64'd1 << k) - 64'($urandom_range(1));
        return $urandom_range(1) ? ~wide : wide;
      end
      default: return 64'($urandom_range(255));
    endcase
  endfunction

  // Random items; str and bin headers are mostly followed by their payload.
  // Undefined kinds are sent as noise and not counted.
  task automatic send_random_items(input int unsigned count);
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 16) begin
        len = ($urandom_range(3) == 0) ? $urandom_range(32, 40) : $urandom_range(6);
        send_item((pick < 8) ? msgpk_pkg::FuncStr : msgpk_pkg::FuncBin, 64'(len));
        sent++;
        repeat (len) begin
          send_item(msgpk_pkg::FuncPayload, {$urandom, $urandom});
          sent++;
        end
      end else if (pick < 21) begin
        send_item(4'($urandom_range(10, 15)), rand_operand());
      end else begin
        send_item(4'($urandom_range(9)), rand_operand());
        sent++;
      end
    end
  endtask

  // Main sequence.
  initial begin
    stream_check = new();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed corners: form boundaries and every kind.
    send_item(msgpk_pkg::FuncUint, 64'h0);
    send_item(msgpk_pkg::FuncUint, 64'h7f);
    send_item(msgpk_pkg::FuncUint, 64'h80);
    send_item(msgpk_pkg::FuncUint, 64'h100);
    send_item(msgpk_pkg::FuncUint, 64'h1_0000);
    send_item(msgpk_pkg::FuncUint, 64'h1_0000_0000);
    send_item(msgpk_pkg::FuncUint, 64'hffff_ffff_ffff_ffff);
    send_item(msgpk_pkg::FuncInt, 64'h7fff_ffff_ffff_ffff);
    send_item(msgpk_pkg::FuncInt, 64'hffff_ffff_ffff_ffe0);
    send_item(msgpk_pkg::FuncInt, 64'hffff_ffff_ffff_ffdf);
    send_item(msgpk_pkg::FuncInt, 64'hffff_ffff_ffff_ff7f);
    send_item(msgpk_pkg::FuncInt, 64'hffff_ffff_ffff_7fff);
    send_item(msgpk_pkg::FuncInt, 64'h8000_0000_0000_0000);
    send_item(msgpk_pkg::FuncStr, 64'd31);
    send_item(msgpk_pkg::FuncStr, 64'd32);
    send_item(msgpk_pkg::FuncStr, 64'h100);
    send_item(msgpk_pkg::FuncStr, 64'h1_2345_6789);
    send_item(msgpk_pkg::FuncBin, 64'd0);
    send_item(msgpk_pkg::FuncBin, 64'h1_0000);
    send_item(msgpk_pkg::FuncBool, 64'd0);
    send_item(msgpk_pkg::FuncBool, 64'h8000_0000_0000_0000);
    send_item(msgpk_pkg::FuncNil, 64'hffff_ffff_ffff_ffff);
    send_item(msgpk_pkg::FuncFloat, 64'hdead_beef_3f80_0000);
    send_item(msgpk_pkg::FuncArray, 64'd15);
    send_item(msgpk_pkg::FuncArray, 64'd16);
    send_item(msgpk_pkg::FuncMap, 64'hffff_ffff_ffff_ffff);
    send_item(msgpk_pkg::FuncPayload, 64'hffff_ffff_ffff_ffa5);
    send_item(4'd15, 64'hffff_ffff_ffff_ffff);

    // Random items with idling on both sides.
    send_random_items(110);

    // Stretch with no idling at all.
    steady = 1'b1;
    send_random_items(60);

    // Receiver holds off while the sender keeps offering items.
    hold_request = 1'b1;
    send_random_items(40);
    steady = 1'b0;

    // Sender pauses until every byte has come out.
    in_valid_i <= 1'b0;
    wait_for_drain();

    send_random_items(110);
    in_valid_i <= 1'b0;
    wait_for_drain();
    repeat (DrainCycles) @(negedge clk_i);

    if (stream_check.error_count == 0) begin
      $display("** msgpack_value_encoder: PASSED **");
    end else begin
      $display("** msgpack_value_encoder: FAILED **");
    end
    $finish;
  end

endmodule
